// ===== hw/rtl/xtkd_pkg.sv =====
// Shared types and constants for the xorshift table key derivation block.
// Used by the channel interfaces, the generator and the top level.
// No dependencies.
`timescale 1ns / 1ps

package xtkd_pkg;

	// Request type codes.
	localparam logic REQ_TABLE = 1'b0;
	localparam logic REQ_SEED  = 1'b1;

	// Key table geometry.
	localparam int TABLE_DEPTH = 64;
	localparam int TABLE_AW    = 6;
	localparam int WORD_BITS   = 32;

	// Key geometry: four words, sixteen bytes, two draws per byte.
	localparam int KEY_WORDS = 4;
	localparam int KEY_BITS  = KEY_WORDS * WORD_BITS;
	localparam int ACC_BITS  = KEY_BITS - 8;
	localparam int CNT_BITS  = 5;
	localparam logic [CNT_BITS-1:0] CNT_LAST = 5'd31;

	// Generator shifts and the default seed used for an all-zero seed.
	localparam int SHIFT_A = 11;
	localparam int SHIFT_B = 8;
	localparam int SHIFT_C = 19;
	localparam logic [31:0] SEED_DEF_0 = 32'h0000_0001;
	localparam logic [31:0] SEED_DEF_1 = 32'h6C07_8967;
	localparam logic [31:0] SEED_DEF_2 = 32'h714A_CB41;
	localparam logic [31:0] SEED_DEF_3 = 32'h4807_7044;

	// Sequencer state codes.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	// Request payload.
	typedef struct packed {
		logic        req_type;
		logic [5:0]  table_index;
		logic [31:0] table_word;
		logic [31:0] seed_word_0;
		logic [31:0] seed_word_1;
		logic [31:0] seed_word_2;
		logic [31:0] seed_word_3;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic [31:0] key_word_0;
		logic [31:0] key_word_1;
		logic [31:0] key_word_2;
		logic [31:0] key_word_3;
	} key_t;

	// Control from the sequencer to the generator.
	typedef struct packed {
		logic load;
		logic step;
	} gen_ctrl_t;

endpackage

// ===== hw/rtl/xtkd_if.sv =====
// Valid/ready channel interfaces for requests and derived keys.
// Depends on xtkd_pkg for the payload types.
`timescale 1ns / 1ps

interface xtkd_req_if import xtkd_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface xtkd_key_if import xtkd_pkg::*; ();
	logic valid;
	logic ready;
	key_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/xorshift_table_key_derivation_top.sv =====
// Top level of the xorshift table key derivation block.
// Depends on xtkd_pkg, xtkd_if, xtkd_ram and xtkd_gen.
`timescale 1ns / 1ps

// Usage:
// The req channel carries two kinds of transaction. A table transaction
// (req_type 0) writes table_word into entry table_index of the 64-word key
// table and gives no result. A seed transaction (req_type 1) loads the
// xorshift128 generator with the four seed words (an all-zero seed selects
// the built-in default seed) and derives a 128-bit key. Each key byte takes
// two generator draws, one per cycle but for the last draw of a key, which
// can wait for the receiver: the first picks a table word through the table
// RAM read port, the second picks the byte lane of the registered read data.
// The result appears on the key channel in the cycle after the last draw,
// key_word_0 holding the first four bytes, first byte highest.
// The block takes no request while a derivation runs; it takes the next one
// as soon as the derivation ends, even while the finished key waits in the
// output register. If the receiver still holds off an older key at the end of
// a derivation, the last draw waits until that key is taken.
// Reset clears the sequencer, the generator state and the output valid flag;
// table entries stay undefined until written.

module xorshift_table_key_derivation_top import xtkd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	xtkd_req_if.sink  req,
	xtkd_key_if.source key
);

	logic                state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [ACC_BITS-1:0] acc_q;
	logic                key_valid_q;
	key_t                key_data_q;

	logic                req_acc;
	logic                seed_acc;
	logic                table_acc;
	logic                last_draw;
	logic                advance;
	logic                byte_phase;
	logic [31:0]         draw;
	logic [31:0]         rd_data;
	logic [7:0]          sel_byte;
	gen_ctrl_t           gen_ctrl;

	// Request handshake.
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign seed_acc  = req_acc && (req.data.req_type == REQ_SEED);
	assign table_acc = req_acc && (req.data.req_type == REQ_TABLE);

	// The last draw waits for room in the output register.
	assign last_draw  = (cnt_q == CNT_LAST);
	assign advance    = (state_q == ST_RUN) && !(last_draw && key_valid_q && !key.ready);
	assign byte_phase = cnt_q[0];

	assign gen_ctrl.load = seed_acc;
	assign gen_ctrl.step = advance;

	xtkd_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (gen_ctrl),
		.seed_0 (req.data.seed_word_0),
		.seed_1 (req.data.seed_word_1),
		.seed_2 (req.data.seed_word_2),
		.seed_3 (req.data.seed_word_3),
		.draw   (draw)
	);

	// Key table; the first draw of a byte addresses the read port.
	xtkd_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (table_acc),
		.waddr (req.data.table_index),
		.wdata (req.data.table_word),
		.re    (advance && !byte_phase),
		.raddr (draw[31:32-TABLE_AW]),
		.rdata (rd_data)
	);

	// The second draw picks the byte lane of the table word.
	always_comb begin
		unique case (draw[31:30])
			2'd0:    sel_byte = rd_data[7:0];
			2'd1:    sel_byte = rd_data[15:8];
			2'd2:    sel_byte = rd_data[23:16];
			default: sel_byte = rd_data[31:24];
		endcase
	end

	// Sequencer: draw counter and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else if (seed_acc) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
		end else if (advance) begin
			cnt_q <= CNT_BITS'(cnt_q + 1'b1);
			if (last_draw) begin
				state_q <= ST_IDLE;
			end
		end
	end

	// Byte accumulator, shifted on every second draw.
	always_ff @(posedge clk) begin
		if (advance && byte_phase) begin
			acc_q <= {acc_q[ACC_BITS-9:0], sel_byte};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance && last_draw) begin
			key_valid_q <= 1'b1;
		end else if (key.ready) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_draw) begin
			key_data_q <= key_t'({acc_q, sel_byte});
		end
	end

	assign key.valid = key_valid_q;
	assign key.data  = key_data_q;

	// A seed transaction starts a derivation.
	a_seed_starts: assert property (@(posedge clk) disable iff (!arst_n)
		seed_acc |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("derivation did not start after a seed transaction");

	// A table transaction never starts a derivation.
	a_table_idle: assert property (@(posedge clk) disable iff (!arst_n)
		table_acc |=> (state_q == ST_IDLE))
		else $error("table transaction left the sequencer running");

	// A key becomes valid only right after the last draw.
	a_key_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_valid_q) |-> $past(advance && last_draw))
		else $error("key became valid without a completed derivation");

	// The draw counter is zero whenever the sequencer is idle.
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("draw counter nonzero while idle");

	// A finished key is never overwritten while it waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid_q && !key.ready) |-> !(advance && last_draw))
		else $error("pending key overwritten");

endmodule

// ===== hw/rtl/xtkd_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module xtkd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data register holds its value while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/xtkd_gen.sv =====
// xorshift128 generator: four state words and one shared step unit.
// Depends on xtkd_pkg for shifts, default seed and the control struct.
`timescale 1ns / 1ps

module xtkd_gen import xtkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  gen_ctrl_t   ctrl,
	input  logic [31:0] seed_0,
	input  logic [31:0] seed_1,
	input  logic [31:0] seed_2,
	input  logic [31:0] seed_3,
	output logic [31:0] draw
);

	logic [31:0] s0_q, s1_q, s2_q, s3_q;
	logic [31:0] t_a, t_b;
	logic        seed_zero;

	// One generator step, evaluated from the current state.
	always_comb begin
		t_a  = s0_q ^ (s0_q << SHIFT_A);
		t_b  = t_a ^ (t_a >> SHIFT_B);
		draw = t_b ^ s3_q ^ (s3_q >> SHIFT_C);
	end

	assign seed_zero = ((seed_0 | seed_1 | seed_2 | seed_3) == 32'd0);

	// State words: loaded from the seed, or rotated by one step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= 32'd0;
			s1_q <= 32'd0;
			s2_q <= 32'd0;
			s3_q <= 32'd0;
		end else if (ctrl.load) begin
			s0_q <= seed_zero ? SEED_DEF_0 : seed_0;
			s1_q <= seed_zero ? SEED_DEF_1 : seed_1;
			s2_q <= seed_zero ? SEED_DEF_2 : seed_2;
			s3_q <= seed_zero ? SEED_DEF_3 : seed_3;
		end else if (ctrl.step) begin
			s0_q <= s1_q;
			s1_q <= s2_q;
			s2_q <= s3_q;
			s3_q <= draw;
		end
	end

endmodule

// ===== tb/xorshift_table_key_derivation_top_tb.sv =====
// Self-checking testbench for the xorshift table key derivation block.
// Depends on xtkd_pkg, the channel interfaces in xtkd_if and the block's top level.
// Table loads and seeds go in through a queued driver, and keys are checked against a predictor.
`timescale 1ns / 1ps

module xorshift_table_key_derivation_top_tb;
	import xtkd_pkg::*;

	// Idle profile codes for the two sides of the block.
	localparam logic [1:0] PH_STEADY    = 2'd0;
	localparam logic [1:0] PH_SEND_IDLE = 2'd1;
	localparam logic [1:0] PH_RECV_HOLD = 2'd2;
	localparam logic [1:0] PH_BOTH_IDLE = 2'd3;

	localparam int RANDOM_ITEMS = 1800;

	// One queued request, with the idle profile in force while it is sent.
	typedef struct {
		req_t       r;
		logic [1:0] phase;
		bit         drain;
	} pend_t;

	// Table indexes read by one derivation, first byte in slot 0.
	typedef logic [15:0][5:0] reads_t;

	logic clk;
	logic arst_n;

	xtkd_req_if req_ch ();
	xtkd_key_if key_ch ();

	xorshift_table_key_derivation_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.key   (key_ch)
	);

	pend_t       pend_q[$];
	key_t        key_exp_q[$];
	logic [31:0] tbl_words[TABLE_DEPTH];
	logic [127:0] gen_state;
	bit          loaded[TABLE_DEPTH];
	logic [1:0]  cur_phase;
	logic        req_taken;
	int          n_err;
	int          n_table;
	int          n_seed;
	int          n_default;
	int          n_keys;

	always #10 clk = ~clk;

	// One xorshift128 step; the state is {s0, s1, s2, s3} and the new draw sits in s3.
	function automatic logic [127:0] xs_advance(input logic [127:0] st);
		logic [31:0] t;
		logic [31:0] d;
		t = st[127:96];
		d = st[31:0];
		t = t ^ (t << SHIFT_A);
		t = t ^ (t >> SHIFT_B);
		t = t ^ d ^ (d >> SHIFT_C);
		return {st[95:0], t};
	endfunction

	// Generator state loaded by a seed transaction; an all-zero seed takes the defaults.
	function automatic logic [127:0] seed_state(input req_t r);
		logic [127:0] s;
		s = {r.seed_word_0, r.seed_word_1, r.seed_word_2, r.seed_word_3};
		if (s == '0) begin
			s = {SEED_DEF_0, SEED_DEF_1, SEED_DEF_2, SEED_DEF_3};
		end
		return s;
	endfunction

	// Table entries a seed will touch; these depend on the seed alone.
	function automatic reads_t seed_reads(input req_t r);
		logic [127:0] st;
		reads_t rd;
		st = seed_state(r);
		for (int k = 0; k < 16; k++) begin
			st = xs_advance(st);
			rd[k] = st[31:26];
			st = xs_advance(st);
		end
		return rd;
	endfunction

	// Predicted key: per byte, one draw picks the table word and the next picks its lane.
	function automatic key_t derive_key(inout logic [127:0] st);
		logic [31:0] words[KEY_WORDS];
		logic [31:0] entry;
		logic [4:0]  sh;
		key_t        k;
		for (int w = 0; w < KEY_WORDS; w++) begin
			words[w] = '0;
			for (int b = 0; b < 4; b++) begin
				st = xs_advance(st);
				entry = tbl_words[st[31:26]];
				st = xs_advance(st);
				sh = {st[31:30], 3'b000};
				words[w] = {words[w][23:0], 8'(entry >> sh)};
			end
		end
		k.key_word_0 = words[0];
		k.key_word_1 = words[1];
		k.key_word_2 = words[2];
		k.key_word_3 = words[3];
		return k;
	endfunction

	// Queue a table load; the seed fields carry noise since the block ignores them.
	task automatic push_table(input logic [5:0] idx, input logic [31:0] word,
			input logic [1:0] ph, input bit drain);
		pend_t p;
		p.r.req_type    = REQ_TABLE;
		p.r.table_index = idx;
		p.r.table_word  = word;
		p.r.seed_word_0 = $urandom;
		p.r.seed_word_1 = $urandom;
		p.r.seed_word_2 = $urandom;
		p.r.seed_word_3 = $urandom;
		p.phase = ph;
		p.drain = drain;
		pend_q.push_back(p);
		loaded[idx] = 1'b1;
	endtask

	// Queue a seed, first loading any table entry it would read that was never written.
	task automatic push_seed(input logic [31:0] s0, input logic [31:0] s1,
			input logic [31:0] s2, input logic [31:0] s3, input logic [1:0] ph);
		pend_t p;
		reads_t rd;
		p.r.req_type    = REQ_SEED;
		p.r.table_index = 6'($urandom);
		p.r.table_word  = $urandom;
		p.r.seed_word_0 = s0;
		p.r.seed_word_1 = s1;
		p.r.seed_word_2 = s2;
		p.r.seed_word_3 = s3;
		p.phase = ph;
		p.drain = 1'b0;
		rd = seed_reads(p.r);
		for (int k = 0; k < 16; k++) begin
			if (!loaded[rd[k]]) begin
				push_table(rd[k], $urandom, ph, 1'b0);
			end
		end
		pend_q.push_back(p);
	endtask

	// Seed word with a bias toward the all-zero and all-one patterns.
	function automatic logic [31:0] seed_pick();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) begin
			return 32'h0000_0000;
		end
		if (sel == 1) begin
			return 32'hFFFF_FFFF;
		end
		return $urandom;
	endfunction

	task automatic check_word(input string field, input logic [31:0] exp_w,
			input logic [31:0] got_w);
		if (got_w !== exp_w) begin
			n_err++;
			if (n_err <= 10) begin
				$display("MISMATCH %s: expected %08h, got %08h at %0t", field, exp_w, got_w,
					$realtime);
			end
		end
	endtask

	// Request driver and receiver stalls, both updated on the falling edge.
	always @(negedge clk) begin
		pend_t nxt;
		logic  load;
		logic  hold;
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				load = 1'b0;
				if (pend_q.size() > 0) begin
					nxt = pend_q[0];
					cur_phase = nxt.phase;
					load = 1'b1;
					// A drain item waits until every outstanding key has come back.
					if (nxt.drain && key_exp_q.size() != 0) begin
						load = 1'b0;
					end else if (nxt.phase == PH_SEND_IDLE && $urandom_range(99) < 60) begin
						load = 1'b0;
					end else if (nxt.phase == PH_BOTH_IDLE && $urandom_range(99) < 8) begin
						load = 1'b0;
					end
				end
				if (load) begin
					void'(pend_q.pop_front());
					req_ch.data <= nxt.r;
				end
				req_ch.valid <= load;
			end
			hold = 1'b0;
			if (cur_phase == PH_RECV_HOLD) begin
				hold = ($urandom_range(99) < 60);
			end else if (cur_phase == PH_BOTH_IDLE) begin
				hold = ($urandom_range(99) < 8);
			end
			key_ch.ready <= !hold;
		end
	end

	// Result check first, then the prediction for any request taken at this edge.
	always @(posedge clk) begin
		key_t exp_k;
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n && key_ch.valid && key_ch.ready) begin
			if (key_exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) begin
					$display("UNEXPECTED key %032h at %0t", key_ch.data, $realtime);
				end
			end else begin
				exp_k = key_exp_q.pop_front();
				check_word("key_word_0", exp_k.key_word_0, key_ch.data.key_word_0);
				check_word("key_word_1", exp_k.key_word_1, key_ch.data.key_word_1);
				check_word("key_word_2", exp_k.key_word_2, key_ch.data.key_word_2);
				check_word("key_word_3", exp_k.key_word_3, key_ch.data.key_word_3);
				n_keys++;
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			if (req_ch.data.req_type == REQ_TABLE) begin
				tbl_words[req_ch.data.table_index] = req_ch.data.table_word;
				n_table++;
			end else begin
				gen_state = seed_state(req_ch.data);
				if ({req_ch.data.seed_word_0, req_ch.data.seed_word_1,
						req_ch.data.seed_word_2, req_ch.data.seed_word_3} == '0) begin
					n_default++;
				end
				key_exp_q.push_back(derive_key(gen_state));
				n_seed++;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [1:0] ph;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		key_ch.ready = 1'b0;
		req_taken = 1'b0;
		cur_phase = PH_STEADY;
		gen_state = '0;
		n_err = 0;
		n_table = 0;
		n_seed = 0;
		n_default = 0;
		n_keys = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_words[i] = '0;
			loaded[i] = 1'b0;
		end

		// Directed: extreme indexes and words, default seed, extreme and one-hot seeds.
		push_table(6'd0, 32'h0000_0000, PH_STEADY, 1'b0);
		push_table(6'd63, 32'hFFFF_FFFF, PH_STEADY, 1'b0);
		push_table(6'd21, 32'hA5C3_5A3C, PH_STEADY, 1'b0);
		push_seed(32'h0, 32'h0, 32'h0, 32'h0, PH_STEADY);
		push_seed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PH_STEADY);
		push_seed(32'h0, 32'h0, 32'h0, 32'h1, PH_STEADY);
		push_seed(32'h8000_0000, 32'h0, 32'h0, 32'h0, PH_STEADY);
		push_table(6'd0, 32'h1234_5678, PH_STEADY, 1'b0);
		push_seed(32'h0, 32'h0, 32'h0, 32'h0, PH_STEADY);

		// Random traffic in blocks that rotate through the idle profiles.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			ph = 2'((i / 150) % 4);
			if (i == RANDOM_ITEMS / 2) begin
				push_table(6'($urandom), $urandom, ph, 1'b1);
			end else if ($urandom_range(99) < 55) begin
				push_table(6'($urandom), $urandom, ph, 1'b0);
			end else if ($urandom_range(99) < 5) begin
				push_seed(32'h0, 32'h0, 32'h0, 32'h0, ph);
			end else begin
				push_seed(seed_pick(), seed_pick(), seed_pick(), seed_pick(), ph);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || req_ch.valid || key_exp_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
		if (key_exp_q.size() != 0) begin
			n_err += key_exp_q.size();
		end

		$display("Run covered %0d table loads and %0d seeds (%0d with the default seed).",
			n_table, n_seed, n_default);
		$display("Checked %0d derived keys; %0d mismatches found.", n_keys, n_err);
		if (n_err == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("Timeout: %0d requests still queued, %0d keys outstanding.",
			pend_q.size(), key_exp_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
